// ----- hw/rtl/rlpm_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the rolling latency percentile monitor.
// No dependencies; imported by rlpm_cell and the top level.
package rlpm_pkg;

  // Item modes
  localparam logic [1:0] MODE_NOTE  = 2'd0;
  localparam logic [1:0] MODE_FLUSH = 2'd1;
  localparam logic [1:0] MODE_QUERY = 2'd2;

  // Percentile register reset value
  localparam logic [6:0] PCT_RESET = 7'd95;

  // Divide by 100: q ~= (x * DIV100_M) >> DIV100_S, low by at most one
  localparam int DIV100_S = 24;
  localparam int DIV100_M = (1 << DIV100_S) / 100;
  localparam int DIV100_D = 100;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_QDIV1,
    S_QDIV2,
    S_LOAD,
    S_COUNT,
    S_SEL,
    S_DONE
  } state_t;

  // Per-cycle commands broadcast to the cell chain
  typedef struct packed {
    logic load;   // copy own entry into the circulating slot, clear rank
    logic count;  // rotate circulating slot, accumulate rank
    logic sel;    // pass selected entry down the chain
  } cell_ctrl_t;

endpackage

// ----- hw/rtl/rlpm_cell.sv -----
`timescale 1ns / 1ps
// One ring entry of the monitor: holds a frame cost, ranks it against the
// circulating copies of all entries, and forwards the selected value.
// Depends on rlpm_pkg.
module rlpm_cell import rlpm_pkg::*; #(
  parameter int W        = 256,
  parameter int SUM_BITS = 48,
  parameter int IDX      = 0,
  localparam int IW      = $clog2(W)
) (
  input  logic                clk,
  input  cell_ctrl_t          ctrl,
  input  logic                wr_en,
  input  logic [SUM_BITS-1:0] wr_data,
  input  logic                own_vld,
  input  logic [IW-1:0]       rank_idx,
  input  logic [SUM_BITS-1:0] circ_val_in,
  input  logic                circ_vld_in,
  input  logic [IW-1:0]       circ_idx_in,
  input  logic [SUM_BITS-1:0] acc_in,
  output logic [SUM_BITS-1:0] circ_val,
  output logic                circ_vld,
  output logic [IW-1:0]       circ_idx,
  output logic [SUM_BITS-1:0] acc
);

  logic [SUM_BITS-1:0] own;
  logic [IW-1:0]       cnt;
  logic                below;

  // Passing entry sorts ahead of ours (ties broken by slot index)
  assign below = circ_vld &&
                 ((circ_val < own) || ((circ_val == own) && (circ_idx < IW'(IDX))));

  // Stored entry
  always_ff @(posedge clk) begin
    if (wr_en) begin
      own <= wr_data;
    end
  end

  // Rank pass and selection pass
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      circ_val <= own;
      circ_vld <= own_vld;
      circ_idx <= IW'(IDX);
      cnt      <= '0;
      acc      <= '0;
    end else if (ctrl.count) begin
      circ_val <= circ_val_in;
      circ_vld <= circ_vld_in;
      circ_idx <= circ_idx_in;
      if (below) begin
        cnt <= cnt + 1'b1;
      end
    end else if (ctrl.sel) begin
      acc <= acc_in | ((own_vld && (cnt == rank_idx)) ? own : '0);
    end
  end

endmodule

// ----- hw/rtl/rolling_latency_percentile_monitor_core.sv -----
`timescale 1ns / 1ps
// Top level of the rolling latency percentile monitor: running sums, control
// sequencer and a chain of WINDOW ranking cells. Depends on rlpm_pkg, rlpm_cell.
//
//  channel | signals                                   | direction
//  --------+-------------------------------------------+----------
//  in      | in_valid in_ready mode cost_us produced   | to block
//  out     | out_valid out_ready total_us max_frame_us | from block
//          | window_fill frames_seen rank_value_us     |
//  cfg     | cfg_valid cfg_ready cfg_data (percentile) | to block
//
// Note, flush and unused items, and a query on an empty ring: the result is written from S_EXEC.
// Other queries run S_QDIV1, S_QDIV2, S_LOAD, S_COUNT, S_SEL and S_DONE; S_COUNT spans one
// full rotation of the cell chain for ranking and S_SEL one pass for selection.
// One item is in flight at a time; a new item is taken once the result
// register is free or being emptied. Reset is synchronous; the ring needs
// no clearing since entries are read only after written. cfg is always ready.
module rolling_latency_percentile_monitor_core import rlpm_pkg::*; #(
  parameter int WINDOW   = 256,
  parameter int SUM_BITS = 48
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  mode,
  input  logic [31:0] cost_us,
  input  logic        produced,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [47:0] total_us,
  output logic [47:0] max_frame_us,
  output logic [8:0]  window_fill,
  output logic [31:0] frames_seen,
  output logic [47:0] rank_value_us,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [6:0]  cfg_data
);

  localparam int IW  = $clog2(WINDOW);
  localparam int FW  = $clog2(WINDOW + 1);
  localparam int PW  = FW + 7;
  localparam int QMW = PW + 18;

  state_t state, state_next;
  cell_ctrl_t ctrl;

  logic [6:0]          pct;
  logic [1:0]          mode_q;
  logic [31:0]         cost_q;
  logic                produced_q;
  logic [SUM_BITS-1:0] total, pending, maxc;
  logic [FW-1:0]       fill;
  logic [31:0]         frames;
  logic [IW-1:0]       wp;
  logic [IW-1:0]       cyc;
  logic [PW-1:0]       prod;
  logic [PW-1:0]       qe;
  logic [IW-1:0]       rank_idx;

  logic [SUM_BITS:0]   tot_sum, pend_sum;
  logic [SUM_BITS-1:0] tot_sat, pend_sat;
  logic                frame_done;
  logic [IW-1:0]       slot;
  logic [QMW-1:0]      qm;
  logic [PW-1:0]       rem, q_fix;
  logic                cyc_last;
  logic                exec_out, sel_out;

  logic [SUM_BITS-1:0] circ_val [WINDOW];
  logic                circ_vld [WINDOW];
  logic [IW-1:0]       circ_idx [WINDOW];
  logic [SUM_BITS-1:0] acc      [WINDOW];

  assign cfg_ready = 1'b1;

  // Saturating sums and frame close
  assign tot_sum    = {1'b0, total} + (SUM_BITS + 1)'(cost_q);
  assign pend_sum   = {1'b0, pending} + (SUM_BITS + 1)'(cost_q);
  assign tot_sat    = tot_sum[SUM_BITS] ? '1 : tot_sum[SUM_BITS-1:0];
  assign pend_sat   = pend_sum[SUM_BITS] ? '1 : pend_sum[SUM_BITS-1:0];
  assign frame_done = (state == S_EXEC) && (mode_q == MODE_NOTE) && produced_q;
  assign slot       = (fill < FW'(WINDOW)) ? fill[IW-1:0] : wp;

  // Rank index: floor(prod / 100) with one correction step, clamped to n-1
  assign qm    = QMW'(prod) * QMW'(DIV100_M);
  assign rem   = prod - PW'(qe * PW'(DIV100_D));
  assign q_fix = (rem >= PW'(DIV100_D)) ? qe + 1'b1 : qe;

  assign cyc_last = (cyc == IW'(WINDOW - 1));

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:  if (in_valid && in_ready) state_next = S_EXEC;
      S_EXEC:  if (mode_q == MODE_QUERY && fill != '0) state_next = S_QDIV1;
               else state_next = S_IDLE;
      S_QDIV1: state_next = S_QDIV2;
      S_QDIV2: state_next = S_LOAD;
      S_LOAD:  state_next = S_COUNT;
      S_COUNT: if (cyc_last) state_next = S_SEL;
      S_SEL:   if (cyc_last) state_next = S_DONE;
      S_DONE:  state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // Control outputs
  always_comb begin
    in_ready   = 1'b0;
    ctrl       = '0;
    exec_out   = 1'b0;
    sel_out    = 1'b0;
    case (state)
      S_IDLE:  in_ready = !out_valid || out_ready;
      S_EXEC:  exec_out = !(mode_q == MODE_QUERY && fill != '0);
      S_LOAD:  ctrl.load = 1'b1;
      S_COUNT: ctrl.count = 1'b1;
      S_SEL:   ctrl.sel = 1'b1;
      S_DONE:  sel_out = 1'b1;
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      pct       <= PCT_RESET;
      total     <= '0;
      pending   <= '0;
      maxc      <= '0;
      fill      <= '0;
      frames    <= '0;
      wp        <= '0;
      cyc       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        pct <= cfg_data;
      end
      // running figures
      if (state == S_EXEC && mode_q == MODE_NOTE) begin
        total <= tot_sat;
        if (produced_q) begin
          pending <= '0;
          if (pend_sat > maxc) begin
            maxc <= pend_sat;
          end
          if (fill < FW'(WINDOW)) begin
            fill <= fill + 1'b1;
          end
          frames <= frames + 1'b1;
          wp     <= (frames == '1 || wp == IW'(WINDOW - 1)) ? '0 : wp + 1'b1;
        end else begin
          pending <= pend_sat;
        end
      end else if (state == S_EXEC && mode_q == MODE_FLUSH) begin
        pending <= '0;
      end
      // pass counter
      if (state == S_COUNT || state == S_SEL) begin
        cyc <= cyc_last ? '0 : cyc + 1'b1;
      end
      // result register handshake
      if (exec_out || sel_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Item capture, divider steps and result payload
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      mode_q     <= mode;
      cost_q     <= cost_us;
      produced_q <= produced;
    end
    if (state == S_EXEC) begin
      prod <= PW'(fill) * PW'(pct);
    end
    if (state == S_QDIV1) begin
      qe <= qm[DIV100_S +: PW];
    end
    if (state == S_QDIV2) begin
      rank_idx <= (q_fix >= PW'(fill)) ? IW'(fill - 1'b1) : IW'(q_fix);
    end
    if (exec_out) begin
      total_us      <= 48'(tot_sat);
      max_frame_us  <= 48'(maxc);
      window_fill   <= 9'(fill);
      frames_seen   <= frames;
      rank_value_us <= '0;
      if (mode_q == MODE_NOTE) begin
        if (produced_q) begin
          max_frame_us <= 48'((pend_sat > maxc) ? pend_sat : maxc);
          window_fill  <= 9'((fill < FW'(WINDOW)) ? fill + 1'b1 : fill);
          frames_seen  <= frames + 1'b1;
        end
      end else begin
        total_us <= 48'(total);
      end
    end
    if (sel_out) begin
      total_us      <= 48'(total);
      max_frame_us  <= 48'(maxc);
      window_fill   <= 9'(fill);
      frames_seen   <= frames;
      rank_value_us <= 48'(acc[WINDOW-1]);
    end
  end

  // Cell chain
  for (genvar i = 0; i < WINDOW; i++) begin : g_cell
    localparam int PREV = (i == 0) ? WINDOW - 1 : i - 1;
    logic [SUM_BITS-1:0] acc_prev;
    assign acc_prev = (i == 0) ? '0 : acc[PREV];
    rlpm_cell #(
      .W        (WINDOW),
      .SUM_BITS (SUM_BITS),
      .IDX      (i)
    ) u_cell (
      .clk         (clk),
      .ctrl        (ctrl),
      .wr_en       (frame_done && (slot == IW'(i))),
      .wr_data     (pend_sat),
      .own_vld     (fill > FW'(i)),
      .rank_idx    (rank_idx),
      .circ_val_in (circ_val[PREV]),
      .circ_vld_in (circ_vld[PREV]),
      .circ_idx_in (circ_idx[PREV]),
      .acc_in      (acc_prev),
      .circ_val    (circ_val[i]),
      .circ_vld    (circ_vld[i]),
      .circ_idx    (circ_idx[i]),
      .acc         (acc[i])
    );
  end

  // Checks
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= FW'(WINDOW))
    else $error("ring fill above window");

  a_frame_step: assert property (@(posedge clk) disable iff (rst)
    frame_done |=> frames == $past(frames) + 32'd1)
    else $error("frame counter did not advance on a closed frame");

  a_take_free: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> (!out_valid || out_ready))
    else $error("item taken while result register is held");

  a_count_flow: assert property (@(posedge clk) disable iff (rst)
    state == S_COUNT |=> (state == S_COUNT || state == S_SEL))
    else $error("rank pass left early");

endmodule
